### design/kslm_pkg.sv
// ----------------------------------------------------------------------------
// kslm_pkg
// Shared types, codes and constants of the keypad scanner / LED multiplexer.
// ----------------------------------------------------------------------------
`default_nettype none

package kslm_pkg;

  // Sizing
  localparam int unsigned MAX_FRAMES  = 8;    // animation frames in use, 1..8
  localparam int unsigned ANIM_PERIOD = 64;   // ticks per animation step, 4..256
  localparam int unsigned PHASE_W     = $clog2(ANIM_PERIOD);

  localparam int unsigned NUM_KEYS    = 16;
  localparam int unsigned NUM_ROWS    = 4;
  localparam int unsigned NUM_COLS    = 4;
  localparam int unsigned FRAME_SLOTS = 8;    // frame storage fixed by the registers
  localparam int unsigned FIDX_W      = 3;

  // Field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned SENSE_W = NUM_COLS;
  localparam int unsigned LED_W   = 16;
  localparam int unsigned ROW_W   = 2;
  localparam int unsigned CODE_W  = 5;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Commands
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLASH = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LED_STATIC  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANIM_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_01   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_23   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_45   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_67   = 3'd5;

  localparam logic [CODE_W-1:0]  NO_KEY     = 5'd16;
  localparam logic [LEN_W-1:0]   LEN_MAX    = LEN_W'(MAX_FRAMES);
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(ANIM_PERIOD - 1);

  // Request from the top level to the key tracker
  typedef struct packed {
    logic               tick;
    logic               read;
    logic [ROW_W-1:0]   row;
    logic [SENSE_W-1:0] sense;
  } key_req_t;

  // Key tracker response for the current transaction
  typedef struct packed {
    logic [NUM_KEYS-1:0] key_state;
    logic [CODE_W-1:0]   key_code;
  } key_rsp_t;

endpackage

`default_nettype wire

### design/kslm_if.sv
// ----------------------------------------------------------------------------
// kslm_if
// Valid/ready channel interfaces for commands in and scan results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface kslm_in_if;
  import kslm_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [SENSE_W-1:0] key_sense;
  logic [LED_W-1:0]   flash_mask;

  modport source (output valid, output command, output key_sense, output flash_mask,
                  input ready);
  modport sink   (input valid, input command, input key_sense, input flash_mask,
                  output ready);
endinterface

interface kslm_out_if;
  import kslm_pkg::*;

  logic                valid;
  logic                ready;
  logic [ROW_W-1:0]    row_index;
  logic [SENSE_W-1:0]  led_drive;
  logic [CODE_W-1:0]   key_code;
  logic [NUM_KEYS-1:0] key_state;

  modport source (output valid, output row_index, output led_drive, output key_code,
                  output key_state, input ready);
  modport sink   (input valid, input row_index, input led_drive, input key_code,
                  input key_state, output ready);
endinterface

`default_nettype wire

### design/kslm_keys.sv
// ----------------------------------------------------------------------------
// kslm_keys
// Debounce, press detection and trigger latch for the 4x4 key matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module kslm_keys (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kslm_pkg::key_req_t req_i,
  output kslm_pkg::key_rsp_t rsp_o
);
  import kslm_pkg::*;

  logic [NUM_KEYS-1:0] deb_q, deb_d;
  logic [NUM_KEYS-1:0] prev_q, prev_d;
  logic [NUM_KEYS-1:0] trig_q, trig_d;
  logic [SENSE_W-1:0]  keys_row;
  logic [CODE_W-1:0]   code;
  logic                found;

  // lowest pending trigger
  always_comb begin
    code  = NO_KEY;
    found = 1'b0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (trig_q[i]) begin
        code  = CODE_W'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    keys_row = ~req_i.sense;
    deb_d    = deb_q;
    prev_d   = prev_q;
    trig_d   = trig_q;
    if (req_i.tick) begin
      // pressed only if the previous scan of this row saw it down too
      deb_d[{req_i.row, 2'b00} +: SENSE_W]  = prev_q[{req_i.row, 2'b00} +: SENSE_W] & keys_row;
      prev_d[{req_i.row, 2'b00} +: SENSE_W] = keys_row;
      trig_d = trig_q | (~deb_q & deb_d);
    end else if (req_i.read && found) begin
      trig_d[code[3:0]] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q  <= '0;
      prev_q <= '0;
      trig_q <= '0;
    end else begin
      deb_q  <= deb_d;
      prev_q <= prev_d;
      trig_q <= trig_d;
    end
  end

  assign rsp_o.key_state = deb_d;
  assign rsp_o.key_code  = req_i.read ? code : NO_KEY;

endmodule

`default_nettype wire

### design/keypad_scan_led_multiplexer.sv
// ----------------------------------------------------------------------------
// keypad_scan_led_multiplexer
// 4x4 key matrix scanner with debounce and trigger latch, plus a 16-LED
// multiplexer with a periodic flash / static / animation pattern update.
// ----------------------------------------------------------------------------
//  channel   dir   handshake          payload
//  in_if     in    valid/ready        command, key_sense, flash_mask
//  out_if    out   valid/ready        row_index, led_drive, key_code, key_state
//  cfg       in    cfg_we_i only      cfg_index_i, cfg_data_i
//
//  One transaction per clock; its result sits in the output register in the
//  cycle after acceptance. in_if.ready is high while the output register is
//  empty or being drained, so a stalled sink holds back exactly one result.
//  Reset (rst_ni, async, active low) clears all but the output payload regs.
//  Every ANIM_PERIOD scan ticks the LED pattern is rebuilt on the wrapping tick.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_scan_led_multiplexer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [kslm_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [kslm_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  kslm_in_if.sink                               in_if,
  kslm_out_if.source                            out_if
);
  import kslm_pkg::*;

  // Configuration registers
  logic [LED_W-1:0]                   led_static_q;
  logic [LEN_W-1:0]                   anim_length_q;
  logic [FRAME_SLOTS-1:0][LED_W-1:0]  frames_q;

  // LED / scan state
  logic [LED_W-1:0]   led_pattern_q, led_pattern_d;
  logic [LED_W-1:0]   pending_q, pending_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [FIDX_W-1:0]  fidx_q, fidx_d;

  // Output register
  logic                out_valid_q;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [SENSE_W-1:0]  drive_q, drive_d;
  logic [CODE_W-1:0]   code_q;
  logic [NUM_KEYS-1:0] state_q;

  logic       accept;
  logic       is_tick;
  logic       wrap;
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] idx_inc;
  logic [LED_W-1:0] frame;
  key_req_t   key_req;
  key_rsp_t   key_rsp;

  assign in_if.ready = !out_valid_q || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign is_tick     = in_if.command == CMD_TICK;
  assign wrap        = phase_q == PHASE_LAST;

  // Key tracker sees only accepted transactions
  assign key_req.tick  = accept && is_tick;
  assign key_req.read  = accept && (in_if.command == CMD_READ);
  assign key_req.row   = phase_q[ROW_W-1:0];
  assign key_req.sense = in_if.key_sense;

  kslm_keys u_keys (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (key_req),
    .rsp_o  (key_rsp)
  );

  // Animation step: lengths above MAX_FRAMES clamp; a stale index is used
  // once and then returns to frame 0.
  always_comb begin
    len_eff = (anim_length_q > LEN_MAX) ? LEN_MAX : anim_length_q;
    idx_inc = {1'b0, fidx_q} + LEN_W'(1);
    frame   = (len_eff != '0) ? frames_q[fidx_q] : '0;
  end

  always_comb begin
    led_pattern_d = led_pattern_q;
    pending_d     = pending_q;
    phase_d       = phase_q;
    fidx_d        = fidx_q;
    row_d         = '0;
    drive_d       = '1;
    if (accept && is_tick) begin
      row_d   = phase_q[ROW_W-1:0];
      drive_d = ~led_pattern_q[{phase_q[ROW_W-1:0], 2'b00} +: SENSE_W];
      phase_d = wrap ? '0 : phase_q + PHASE_W'(1);
      if (wrap) begin
        led_pattern_d = pending_q ^ (led_static_q | frame);
        pending_d     = '0;
        if (len_eff != '0) begin
          fidx_d = (idx_inc >= len_eff) ? '0 : idx_inc[FIDX_W-1:0];
        end
      end
    end else if (accept && (in_if.command == CMD_FLASH)) begin
      pending_d = in_if.flash_mask;
    end
    // a new animation length restarts at frame 0
    if (cfg_we_i && (cfg_index_i == REG_ANIM_LENGTH)) begin
      fidx_d = '0;
    end
  end

  // State and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_static_q  <= '0;
      anim_length_q <= '0;
      frames_q      <= '0;
      led_pattern_q <= '0;
      pending_q     <= '0;
      phase_q       <= '0;
      fidx_q        <= '0;
    end else begin
      led_pattern_q <= led_pattern_d;
      pending_q     <= pending_d;
      phase_q       <= phase_d;
      fidx_q        <= fidx_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_LED_STATIC:  led_static_q <= cfg_data_i[LED_W-1:0];
          REG_ANIM_LENGTH: anim_length_q <= cfg_data_i[LEN_W-1:0];
          REG_FRAMES_01:   frames_q[1:0] <= cfg_data_i;
          REG_FRAMES_23:   frames_q[3:2] <= cfg_data_i;
          REG_FRAMES_45:   frames_q[5:4] <= cfg_data_i;
          REG_FRAMES_67:   frames_q[7:6] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Output register: valid has reset, payload loads on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q   <= row_d;
      drive_q <= drive_d;
      code_q  <= key_rsp.key_code;
      state_q <= key_rsp.key_state;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.row_index = row_q;
  assign out_if.led_drive = drive_q;
  assign out_if.key_code  = code_q;
  assign out_if.key_state = state_q;

`ifndef SYNTHESIS
  // every accepted transaction leaves a result behind
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted transaction produced no result");

  // non-tick results keep the LEDs dark on row 0
  a_non_tick_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_tick) |=> (row_q == '0 && drive_q == '1))
    else $error("non-tick result drives LEDs");

  // the wrapping tick restarts the phase and consumes the flash mask
  a_wrap_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_tick && wrap && !cfg_we_i) |=> (phase_q == '0 && pending_q == '0))
    else $error("animation step did not wrap phase or clear flash");
`endif

endmodule

`default_nettype wire
